// ----- design/ccx_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 stream XOR core.
// No dependencies.
`default_nettype none

package ccx_pkg;

  localparam int CcDoubleRounds = 10;

  localparam logic [31:0] CcSigma0 = 32'h61707865;
  localparam logic [31:0] CcSigma1 = 32'h3320646e;
  localparam logic [31:0] CcSigma2 = 32'h79622d32;
  localparam logic [31:0] CcSigma3 = 32'h6b206574;

  localparam int CcCfgIdxW = 3;

  typedef enum logic [CcCfgIdxW-1:0] {
    CFG_KEY0       = 3'd0,
    CFG_KEY1       = 3'd1,
    CFG_KEY2       = 3'd2,
    CFG_KEY3       = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5,
    CFG_START_CNT  = 3'd6,
    CFG_NONCE_FORM = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_t;

  typedef logic [15:0][31:0] blk_words_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

  function automatic qr_t quarter_round(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    qr_t q;
    q.a = a;
    q.b = b;
    q.c = c;
    q.d = d;
    q.a = q.a + q.b; q.d = rotl32(q.d ^ q.a, 16);
    q.c = q.c + q.d; q.b = rotl32(q.b ^ q.c, 12);
    q.a = q.a + q.b; q.d = rotl32(q.d ^ q.a, 8);
    q.c = q.c + q.d; q.b = rotl32(q.b ^ q.c, 7);
    return q;
  endfunction

  // Initial state of the block function.
  function automatic blk_words_t init_block(input logic [3:0][63:0] key,
                                            input logic [63:0] nonce_lo,
                                            input logic [31:0] nonce_hi,
                                            input logic form,
                                            input logic [63:0] blk);
    blk_words_t w;
    w[0] = CcSigma0;
    w[1] = CcSigma1;
    w[2] = CcSigma2;
    w[3] = CcSigma3;
    for (int i = 0; i < 4; i++) begin
      w[4 + 2*i] = key[i][31:0];
      w[5 + 2*i] = key[i][63:32];
    end
    w[12] = blk[31:0];
    if (form) begin
      w[13] = blk[63:32];
      w[14] = nonce_lo[31:0];
      w[15] = nonce_lo[63:32];
    end else begin
      w[13] = nonce_lo[31:0];
      w[14] = nonce_lo[63:32];
      w[15] = nonce_hi;
    end
    return w;
  endfunction

  // Byte mask for a count already limited to 0..8.
  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    for (int k = 0; k < 8; k++) begin
      m[8*k +: 8] = (4'(k) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/chacha20_stream_xor_core.sv -----
// ChaCha20 stream XOR core: one 64-bit message word in, one word out. Depends on ccx_pkg.
// Flow: an item that continues the current block goes from ST_IDLE to ST_EMIT; an item that
// starts a new block goes through ST_ROUND for every round, then ST_FEED, then ST_EMIT.
// One item at a time: in_ready is high only in ST_IDLE, so the next item is accepted only
// after the result is emitted, and emitting can also wait on out_ready.
// Reset (rst_n, synchronous): configuration registers, counter and message state cleared, block idle.
`default_nettype none

module chacha20_stream_xor_core
  import ccx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = CcDoubleRounds
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // configuration
  input  wire                  cfg_we,
  input  wire [CcCfgIdxW-1:0]  cfg_index,
  input  wire [63:0]           cfg_wdata,
  // input items
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [63:0]           in_data_word,
  input  wire [3:0]            in_byte_count,
  input  wire                  in_last_word,
  // result items
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [63:0]          out_result_word,
  output logic [3:0]           out_result_count,
  output logic                 out_result_last
);

  localparam int NumRounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW      = $clog2(NumRounds);
  localparam logic [RndW-1:0] RndLast = RndW'(NumRounds - 1);

  // configuration registers
  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;
  logic [63:0]      start_cnt_r;
  logic             form_r;

  state_t           state_r, state_nxt;
  logic [RndW-1:0]  rnd_r, rnd_nxt;
  blk_words_t       w_r, w_nxt;
  logic [63:0]      blk_r, blk_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic             mid_r, mid_nxt;
  logic [63:0]      data_r;
  logic [3:0]       count_r;
  logic             last_r;
  logic             out_valid_r;
  logic [63:0]      out_word_r;
  logic [3:0]       out_count_r;
  logic             out_last_r;

  logic             accept;
  logic             emit;
  logic [2:0]       pos_eff;
  logic [63:0]      blk_eff;
  logic [63:0]      blk_inc;
  logic [3:0]       count_sat;
  blk_words_t       init_w;
  blk_words_t       rnd_w;
  logic [63:0]      ks_word;
  logic [3:0][3:0]  ia, ib, ic, id;
  qr_t  [3:0]       qr_out;

  assign accept    = in_valid && in_ready;
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE);
  assign count_sat = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;

  // a new message restarts at the configured counter
  assign pos_eff = mid_r ? pos_r : 3'd0;
  assign blk_eff = mid_r ? blk_r : (form_r ? start_cnt_r : {32'd0, start_cnt_r[31:0]});
  assign blk_inc = form_r ? (blk_r + 64'd1) : {32'd0, blk_r[31:0] + 32'd1};

  assign init_w  = init_block(key_r, nonce_lo_r, nonce_hi_r, form_r,
                              (state_r == ST_IDLE) ? blk_eff : blk_r);
  assign ks_word = {w_r[{pos_r, 1'b1}], w_r[{pos_r, 1'b0}]};

  // shared round unit: four quarter-round lanes, column or diagonal by round parity
  always_comb begin
    rnd_w = w_r;
    for (int l = 0; l < 4; l++) begin
      ia[l] = {2'b00, 2'(l)};
      ib[l] = {2'b01, 2'(l + (rnd_r[0] ? 1 : 0))};
      ic[l] = {2'b10, 2'(l + (rnd_r[0] ? 2 : 0))};
      id[l] = {2'b11, 2'(l + (rnd_r[0] ? 3 : 0))};
      qr_out[l] = quarter_round(w_r[ia[l]], w_r[ib[l]], w_r[ic[l]], w_r[id[l]]);
      rnd_w[ia[l]] = qr_out[l].a;
      rnd_w[ib[l]] = qr_out[l].b;
      rnd_w[ic[l]] = qr_out[l].c;
      rnd_w[id[l]] = qr_out[l].d;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (pos_eff == 3'd0) ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RndLast) begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    rnd_nxt = rnd_r;
    w_nxt   = w_r;
    blk_nxt = blk_r;
    pos_nxt = pos_r;
    mid_nxt = mid_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt = pos_eff;
          blk_nxt = blk_eff;
          rnd_nxt = '0;
          if (pos_eff == 3'd0) begin
            w_nxt = init_w;
          end
        end
      end
      ST_ROUND: begin
        w_nxt   = rnd_w;
        rnd_nxt = rnd_r + RndW'(1);
      end
      ST_FEED: begin
        for (int i = 0; i < 16; i++) begin
          w_nxt[i] = w_r[i] + init_w[i];
        end
        blk_nxt = blk_inc;
      end
      ST_EMIT: begin
        if (emit) begin
          mid_nxt = !last_r;
          pos_nxt = last_r ? 3'd0 : pos_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_cnt_r <= '0;
      form_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KEY0:       key_r[0]    <= cfg_wdata;
        CFG_KEY1:       key_r[1]    <= cfg_wdata;
        CFG_KEY2:       key_r[2]    <= cfg_wdata;
        CFG_KEY3:       key_r[3]    <= cfg_wdata;
        CFG_NONCE_LOW:  nonce_lo_r  <= cfg_wdata;
        CFG_NONCE_HIGH: nonce_hi_r  <= cfg_wdata[31:0];
        CFG_START_CNT:  start_cnt_r <= cfg_wdata;
        CFG_NONCE_FORM: form_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      blk_r       <= '0;
      pos_r       <= '0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      blk_r   <= blk_nxt;
      pos_r   <= pos_nxt;
      mid_r   <= mid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (accept) begin
      data_r  <= in_data_word;
      count_r <= count_sat;
      last_r  <= in_last_word;
    end
    if (emit) begin
      out_word_r  <= (data_r ^ ks_word) & byte_mask(count_r);
      out_count_r <= count_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_word  = out_word_r;
  assign out_result_count = out_count_r;
  assign out_result_last  = out_last_r;

  // the first word of a message always generates a block
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && !mid_r |=> state_r == ST_ROUND)
    else $error("new message did not start block generation");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> rnd_r <= RndLast)
    else $error("round counter overran");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FEED |=> state_r == ST_EMIT && $past(blk_r) != blk_r
      || (!form_r && $past(blk_r[31:0]) == 32'hffffffff) || (form_r && $past(blk_r) == '1))
    else $error("feed-forward did not advance the counter");

  assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last_r |=> mid_r && pos_r == $past(pos_r) + 3'd1)
    else $error("word position not advanced within message");

  assert property (@(posedge clk) disable iff (!rst_n)
    emit && last_r |=> !mid_r && pos_r == 3'd0)
    else $error("message state not cleared after last item");

endmodule

`default_nettype wire

// ----- dv/tb_chacha20_stream_xor_core.sv -----
// Self-checking testbench for chacha20_stream_xor_core: directed table, then random messages.
// Every result is checked against a ChaCha20 keystream predictor kept in this file, or against a typed row.
// Depends on ccx_pkg and the core RTL.

module tb_chacha20_stream_xor_core;
  import ccx_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } cipher_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [63:0] val;       // data word, or register value on a config row
    logic [3:0]  cnt;
    logic        last;
    logic        typed;     // expected result given in the row
    logic [63:0] want_word;
    logic [3:0]  want_cnt;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = CFG_KEY0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_word;
  logic [3:0]  out_result_count;
  logic        out_result_last;

  chacha20_stream_xor_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_word     (in_data_word),
    .in_byte_count    (in_byte_count),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word  (out_result_word),
    .out_result_count (out_result_count),
    .out_result_last  (out_result_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  logic [63:0] key_w [4] = '{default: '0};
  logic [63:0] nonce_lo = '0;
  logic [31:0] nonce_hi = '0;
  logic [63:0] ctr_start = '0;
  logic        form64 = 1'b0;

  logic [63:0] pad_words [8] = '{default: '0};
  logic [2:0]  pad_slot = '0;
  logic [63:0] blk_ctr = '0;
  logic        msg_open = 1'b0;
  logic [31:0] mix_w [16] = '{default: '0};

  cipher_out_t want_q [$];
  int          err_count = 0;
  int          n_sent = 0;
  int          idle_pct = 20;
  int          stall_pct = 20;
  int          hold_left = 0;
  int          cyc = 0;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void mix_quarter(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // New 64-byte pad from key, nonce and counter; counter then steps and wraps per form.
  function automatic void refill_pad();
    logic [31:0] init_w [16];
    init_w[0] = CcSigma0;
    init_w[1] = CcSigma1;
    init_w[2] = CcSigma2;
    init_w[3] = CcSigma3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2*i] = key_w[i][31:0];
      init_w[5 + 2*i] = key_w[i][63:32];
    end
    init_w[12] = blk_ctr[31:0];
    if (form64) begin
      init_w[13] = blk_ctr[63:32];
      init_w[14] = nonce_lo[31:0];
      init_w[15] = nonce_lo[63:32];
    end else begin
      init_w[13] = nonce_lo[31:0];
      init_w[14] = nonce_lo[63:32];
      init_w[15] = nonce_hi;
    end
    mix_w = init_w;
    for (int r = 0; r < CcDoubleRounds; r++) begin
      mix_quarter(0, 4, 8, 12);  mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14); mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15); mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);  mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) mix_w[i] = mix_w[i] + init_w[i];
    for (int i = 0; i < 8; i++) pad_words[i] = {mix_w[2*i + 1], mix_w[2*i]};
    blk_ctr = form64 ? blk_ctr + 64'd1 : {32'd0, blk_ctr[31:0] + 32'd1};
  endfunction

  function automatic cipher_out_t keystream_xor(input logic [63:0] data, input logic [3:0] cnt,
                                                input logic last);
    cipher_out_t r;
    logic [3:0]  n;
    logic [63:0] keep;
    n = (cnt > 4'd8) ? 4'd8 : cnt;
    if (!msg_open) begin
      pad_slot = '0;
      blk_ctr  = form64 ? ctr_start : {32'd0, ctr_start[31:0]};
    end
    if (pad_slot == 3'd0) refill_pad();
    keep = (n == 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    r.word  = (data ^ pad_words[pad_slot]) & keep;
    r.count = n;
    r.last  = last;
    // a short word that is not last still uses a whole slot
    if (last) begin
      msg_open = 1'b0;
      pad_slot = '0;
    end else begin
      msg_open = 1'b1;
      pad_slot = pad_slot + 3'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int gap_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    err_count++;
  endtask

  task automatic push_word(input logic [63:0] data, input logic [3:0] cnt, input logic last,
                           input logic typed, input cipher_out_t typed_out);
    cipher_out_t p;
    cfg_we <= 1'b0;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= cnt;
    in_last_word  <= last;
    do @(posedge clk); while (!in_ready);
    p = keystream_xor(data, cnt, last);
    want_q.push_back(typed ? typed_out : p);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (want_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_KEY0:       key_w[0]  = v;
      CFG_KEY1:       key_w[1]  = v;
      CFG_KEY2:       key_w[2]  = v;
      CFG_KEY3:       key_w[3]  = v;
      CFG_NONCE_LOW:  nonce_lo  = v;
      CFG_NONCE_HIGH: nonce_hi  = v[31:0];
      CFG_START_CNT:  ctr_start = v;
      CFG_NONCE_FORM: form64    = v[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] reg_value(input cfg_reg_t r);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (r == CFG_START_CNT) begin
      // counters near both wrap points
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = 64'h0000_0000_FFFF_FFFF;
        2: v = '1;
        3: v = 64'h0000_0000_FFFF_FFFE;
        4: v = 64'hFFFF_FFFF_FFFF_FFFE;
        default: ;
      endcase
    end else if (r != CFG_NONCE_FORM) begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic rand_config();
    cfg_reg_t r;
    logic     every_reg;
    every_reg = ($urandom_range(0, 3) == 0);
    r = r.first();
    do begin
      if (every_reg || $urandom_range(0, 1) == 1) write_reg(r, reg_value(r));
      r = r.next();
    end while (r != r.first());
  endtask

  // ---------------------------------------------------------------- directed table
  // kind, register, data or value, count, last, typed, want word, want count
  step_row_t dir_tab [0:33] = '{
    '{ROW_ITEM, CFG_KEY0, 64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, '0, '0}, // raw pad
    '{ROW_ITEM, CFG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0123_4567_89AB_CDEF, 4'd1,  1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'hFEDC_BA98_7654_3210, 4'd7,  1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b1, '0, 4'd0},
    '{ROW_ITEM, CFG_KEY0, 64'hA5A5_A5A5_A5A5_A5A5, 4'd9,  1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h5A5A_5A5A_5A5A_5A5A, 4'd15, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, '0, '0}, // next block
    '{ROW_ITEM, CFG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd3,  1'b1, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h1234_5678_9ABC_DEF0, 4'd0,  1'b1, 1'b1, '0, 4'd0},
    '{ROW_CFG,  CFG_KEY0,       64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_KEY1,       64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_KEY2,       64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_KEY3,       64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_NONCE_LOW,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_NONCE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_START_CNT,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_NONCE_FORM, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0, 1'b0, '0, '0},
    // 32-bit counter wraps to zero at the ninth word
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h0, 4'd8, 1'b1, 1'b0, '0, '0},
    // register changes while a message is open
    '{ROW_ITEM, CFG_KEY0, 64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_KEY2,       64'h0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_NONCE_FORM, 64'h1, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_START_CNT,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'hF0F0_F0F0_F0F0_F0F0, 4'd8, 1'b0, 1'b0, '0, '0},
    '{ROW_ITEM, CFG_KEY0, 64'h3C3C_3C3C_3C3C_3C3C, 4'd5, 1'b1, 1'b0, '0, '0}
  };

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin : rx_side
    cipher_out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        flag_mismatch("result item with nothing expected", out_result_word, '0);
      end else begin
        w = want_q.pop_front();
        if (out_result_word !== w.word)
          flag_mismatch("result_word", out_result_word, w.word);
        if (out_result_count !== w.count)
          flag_mismatch("result_count", 64'(out_result_count), 64'(w.count));
        if (out_result_last !== w.last)
          flag_mismatch("result_last", 64'(out_result_last), 64'(w.last));
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      hold_left <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stim
    int          rand_target;
    int          msg_len;
    logic        open_end;
    logic        fin;
    logic [3:0]  cnt;
    logic [63:0] data;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].val);
      end else begin
        push_word(dir_tab[i].val, dir_tab[i].cnt, dir_tab[i].last, dir_tab[i].typed,
                  '{dir_tab[i].want_word, dir_tab[i].want_cnt, dir_tab[i].last});
      end
    end

    // random messages; mostly well formed, some left open or with odd counts
    rand_target = n_sent + RAND_ITEMS;
    while (n_sent < rand_target) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 30;
        default: stall_pct = 60;
      endcase
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        rand_config();
      end
      msg_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 10);
      open_end = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < msg_len; k++) begin
        fin = (k == msg_len - 1) && !open_end;
        if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(0, 15));
        else if (fin) cnt = 4'($urandom_range(1, 8));
        else cnt = 4'd8;
        case ($urandom_range(0, 19))
          0: data = '0;
          1: data = '1;
          default: data = {$urandom, $urandom};
        endcase
        push_word(data, cnt, fin, 1'b0, '0);
      end
    end

    drain_results();
    cfg_we <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
